[rtl/ckacw_pkg.sv]
package ckacw_pkg;

    localparam int DATA_W = 32;
    localparam int APB_AW = 5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [2:0] REG_RED    = 3'd0;
    localparam logic [2:0] REG_GREEN  = 3'd1;
    localparam logic [2:0] REG_BLUE   = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    localparam logic [7:0]  THRESH_RESET = 8'd235;
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_thresh;

    // per-transaction decisions taken at input acceptance
    typedef struct packed {
        logic emit;       // a result follows
        logic pixel;      // pixel result (not flush)
        logic store;      // write incoming pixel into the line
        logic border;     // alpha forced to zero
        logic frame_end;
    } t_item_ctl;

    function automatic logic passes(logic [DATA_W-1:0] px, t_thresh th);
        logic ok;
        ok = (px[7:0] >= th.red) && (px[15:8] >= th.green) && (px[23:16] >= th.blue);
        return ok;
    endfunction

endpackage

[rtl/ckacw_ram.sv]
module ckacw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ckacw_cfg.sv]
module ckacw_cfg #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ckacw_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output ckacw_pkg::t_thresh            o_thresh,
    output logic [$clog2(MAX_WIDTH):0]    o_eff_width,
    output logic [$clog2(MAX_HEIGHT):0]   o_eff_height
);

    import ckacw_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH) + 1;
    localparam int HW  = $clog2(MAX_HEIGHT) + 1;
    localparam int WCW = (WW > 12) ? WW : 12;
    localparam int HCW = (HW > 13) ? HW : 13;

    logic [7:0]  r_red, r_green, r_blue;
    logic [11:0] r_width;
    logic [12:0] r_height;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red    <= THRESH_RESET;
            r_green  <= THRESH_RESET;
            r_blue   <= THRESH_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RED:    r_red    <= pwdata[7:0];
                REG_GREEN:  r_green  <= pwdata[7:0];
                REG_BLUE:   r_blue   <= pwdata[7:0];
                REG_WIDTH:  r_width  <= pwdata[11:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RED:    prdata = 32'(r_red);
            REG_GREEN:  prdata = 32'(r_green);
            REG_BLUE:   prdata = 32'(r_blue);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign o_thresh = '{red: r_red, green: r_green, blue: r_blue};

    // clamp geometry to 1..MAX
    always_comb begin
        if (r_width == '0) begin
            o_eff_width = WW'(1);
        end else if (WCW'(r_width) > WCW'(MAX_WIDTH)) begin
            o_eff_width = WW'(MAX_WIDTH);
        end else begin
            o_eff_width = WW'(r_width);
        end
        if (r_height == '0) begin
            o_eff_height = HW'(1);
        end else if (HCW'(r_height) > HCW'(MAX_HEIGHT)) begin
            o_eff_height = HW'(MAX_HEIGHT);
        end else begin
            o_eff_height = HW'(r_height);
        end
    end

endmodule

[rtl/ckacw_pos.sv]
module ckacw_pos #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_op,
    input  logic [$clog2(MAX_WIDTH):0]      i_eff_width,
    input  logic [$clog2(MAX_HEIGHT):0]     i_eff_height,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_rd_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_right_addr,
    output ckacw_pkg::t_item_ctl            o_ctl,
    output logic                            o_flushing
);

    import ckacw_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;

    logic [CW-1:0] r_col, r_flush_cnt;
    logic [RW-1:0] r_row;
    logic          r_flushing;

    logic line_done, frame_done, flush_done;

    assign line_done  = (WW'(r_col) + WW'(1)) >= i_eff_width;
    assign frame_done = (HW'(r_row) + HW'(1)) >= i_eff_height;
    assign flush_done = (WW'(r_flush_cnt) + WW'(1)) >= i_eff_width;

    assign o_flushing   = r_flushing;
    assign o_right_addr = (r_col == CW'(MAX_WIDTH - 1)) ? '0 : r_col + CW'(1);

    always_comb begin
        o_ctl = '0;
        if (i_op == OP_FLUSH) begin
            o_rd_addr       = r_flush_cnt;
            o_ctl.emit      = r_flushing;
            o_ctl.border    = 1'b1;
            o_ctl.frame_end = flush_done;
        end else begin
            o_rd_addr    = r_col;
            o_ctl.store  = !r_flushing;
            o_ctl.emit   = !r_flushing && (r_row != '0);
            o_ctl.pixel  = 1'b1;
            o_ctl.border = (r_row == RW'(1)) || (HW'(r_row) >= i_eff_height) ||
                           (r_col == '0) || line_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_flush_cnt <= '0;
            r_flushing  <= 1'b0;
        end else if (i_accept) begin
            if (i_op == OP_FLUSH) begin
                if (r_flushing) begin
                    if (flush_done) begin
                        r_flushing  <= 1'b0;
                        r_flush_cnt <= '0;
                        r_row       <= '0;
                        r_col       <= '0;
                    end else begin
                        r_flush_cnt <= r_flush_cnt + CW'(1);
                    end
                end
            end else if (!r_flushing) begin
                if (line_done) begin
                    r_col <= '0;
                    if (frame_done) begin
                        r_flushing  <= 1'b1;
                        r_flush_cnt <= '0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

endmodule

[rtl/color_key_alpha_cross_window_top.sv]
// Colour key to alpha over a cross-shaped window, one line of delay.
// Slave stream: i_s_tdata = {alpha, blue, green, red}, i_s_tuser = 0 for a
// pixel, 1 for a flush tick. Master stream: o_m_tdata = {alpha, blue, green,
// red} of the pixel one line above, o_m_tlast marks the last pixel of a frame.
// Pixels of the first line give no result; each later pixel releases the pixel
// above it. After the last pixel of a frame, one flush tick per pixel of the
// last line drains it. Pixels during the drain and flush ticks outside it are
// taken and dropped.
// Throughput: one transaction per cycle while the receiver takes results. The
// line RAM read and the input stage registers capture at the accepting edge;
// keying then loads the result register, which drives o_m_tvalid.
// Alpha is zero on the border and where the pixel and its four neighbours all
// meet the red, green and blue thresholds, set over the APB port.
// Reset (synchronous, active low) restores the register defaults, clears the
// position and empties the pipeline; line RAM contents are left as they are.
// When the receiver stalls the result register holds and o_s_tready drops once
// the keying stage is also full.
module color_key_alpha_cross_window_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ckacw_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [ckacw_pkg::DATA_W-1:0] i_s_tdata,  // red, green, blue, alpha
    input  logic                         i_s_tuser,  // op
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [ckacw_pkg::DATA_W-1:0] o_m_tdata,  // red, green, blue, alpha
    output logic                         o_m_tlast   // frame_end
);

    import ckacw_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    t_thresh                   thresh;
    logic [CW:0]               eff_width;
    logic [$clog2(MAX_HEIGHT):0] eff_height;
    logic                      in_accept;
    logic [CW-1:0]             rd_addr, right_addr;
    t_item_ctl                 item_ctl;
    logic                      flushing;
    logic [DATA_W-1:0]         line_up, line_right;
    logic                      pass_up;

    logic                      r_s1_valid;
    t_item_ctl                 r_s1_ctl;
    logic [CW-1:0]             r_s1_col;
    logic [DATA_W-1:0]         r_s1_in;
    logic                      r_left_pass;
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_out_data;
    logic                      r_out_last;

    logic                      s1_adv, centre, keyed;
    logic [7:0]                alpha;

    ckacw_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_thresh     (thresh),
        .o_eff_width  (eff_width),
        .o_eff_height (eff_height)
    );

    ckacw_pos #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_op         (i_s_tuser),
        .i_eff_width  (eff_width),
        .i_eff_height (eff_height),
        .o_rd_addr    (rd_addr),
        .o_right_addr (right_addr),
        .o_ctl        (item_ctl),
        .o_flushing   (flushing)
    );

    // two copies of the line so the pixel above and its right neighbour
    // are read in the same cycle
    ckacw_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (in_accept && item_ctl.store),
        .i_waddr (rd_addr),
        .i_wdata (i_s_tdata),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (line_up)
    );

    ckacw_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (in_accept && item_ctl.store),
        .i_waddr (rd_addr),
        .i_wdata (i_s_tdata),
        .i_re    (in_accept),
        .i_raddr (right_addr),
        .o_rdata (line_right)
    );

    ckacw_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_pass (
        .i_clk   (i_clk),
        .i_we    (s1_adv && r_s1_ctl.pixel),
        .i_waddr (r_s1_col),
        .i_wdata (centre),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (pass_up)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || !r_out_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;

    assign centre = passes(line_up, thresh);
    assign keyed  = pass_up && r_left_pass && centre &&
                    passes(line_right, thresh) && passes(r_s1_in, thresh);
    assign alpha  = (r_s1_ctl.border || keyed) ? 8'd0 : line_up[31:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_left_pass <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= item_ctl.emit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1_ctl.pixel) begin
                r_left_pass <= centre;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctl <= item_ctl;
            r_s1_col <= rd_addr;
            r_s1_in  <= i_s_tdata;
        end
        if (s1_adv) begin
            r_out_data <= {alpha, line_up[23:0]};
            r_out_last <= r_s1_ctl.frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_last_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[31:24] == 8'd0))
        else $error("frame end with non-zero alpha");

    a_pixel_no_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.pixel) |-> !r_s1_ctl.frame_end)
        else $error("pixel result marked as frame end");

    a_end_leaves_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.frame_end) |-> !flushing)
        else $error("still draining after last line pixel");

endmodule

[test/color_key_alpha_cross_window_top_test.sv]
`timescale 1ns / 100ps

module color_key_alpha_cross_window_top_test;
    import ckacw_pkg::*;

    localparam int LINE_MAX      = 2048;
    localparam int ROWS_MAX      = 4096;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CALM_AT       = 520;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 3000;

    class alpha_keyer;
        typedef struct {
            logic [31:0] data;
            logic        last;
        } out_px_t;

        logic [7:0]  thr_red, thr_green, thr_blue;
        logic [11:0] width_reg;
        logic [12:0] height_reg;
        logic [31:0] line_px [LINE_MAX];
        bit          line_ok [LINE_MAX];
        int unsigned col, row, drain_pos;
        bit          left_ok, draining;
        out_px_t     delayed_px [$];
        int          errors;

        function new();
            thr_red    = THRESH_RESET;
            thr_green  = THRESH_RESET;
            thr_blue   = THRESH_RESET;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col        = 0;
            row        = 0;
            drain_pos  = 0;
            left_ok    = 0;
            draining   = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_RED:    thr_red = v[7:0];
                REG_GREEN:  thr_green = v[7:0];
                REG_BLUE:   thr_blue = v[7:0];
                REG_WIDTH:  width_reg = v[11:0];
                REG_HEIGHT: height_reg = v[12:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > LINE_MAX) w = LINE_MAX;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < 1) h = 1;
            if (h > ROWS_MAX) h = ROWS_MAX;
            return h;
        endfunction

        function bit key_ok(logic [31:0] px);
            return px[7:0] >= thr_red && px[15:8] >= thr_green && px[23:16] >= thr_blue;
        endfunction

        function int pending();
            return delayed_px.size();
        endfunction

        // one accepted input transaction
        function void push_item(logic op, logic [31:0] px);
            int unsigned w, h, c, r;
            logic [31:0] above;
            logic [7:0]  alpha;
            bit          centre, border;
            out_px_t     e;
            w = eff_width();
            h = eff_height();
            if (op == OP_FLUSH) begin
                if (!draining) return;
                e.data = {8'h00, line_px[drain_pos][23:0]};
                e.last = (drain_pos + 1 >= w);
                delayed_px.push_back(e);
                if (e.last) begin
                    draining  = 0;
                    drain_pos = 0;
                    row       = 0;
                    col       = 0;
                end else begin
                    drain_pos++;
                end
                return;
            end
            if (draining) return;
            c = col;
            if (row > 0) begin
                above  = line_px[c];
                r      = row - 1;
                centre = key_ok(above);
                border = (r == 0) || (r + 1 >= h) || (c == 0) || (c + 1 >= w);
                alpha  = above[31:24];
                if (border) begin
                    alpha = 8'h00;
                end else if (line_ok[c] && left_ok && centre && key_ok(line_px[c + 1])
                             && key_ok(px)) begin
                    alpha = 8'h00;
                end
                e.data = {alpha, above[23:0]};
                e.last = 1'b0;
                delayed_px.push_back(e);
                line_ok[c] = centre;
                left_ok    = centre;
            end
            line_px[c] = px;
            if (col + 1 >= w) begin
                col = 0;
                if (row + 1 >= h) begin
                    draining  = 1;
                    drain_pos = 0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        endfunction

        function void check_pixel(logic [31:0] data, logic last);
            string   lane [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};
            out_px_t e;
            if (delayed_px.size() == 0) begin
                $error("result with none expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            e = delayed_px.pop_front();
            for (int k = 0; k < 4; k++) begin
                if (data[8*k +: 8] !== e.data[8*k +: 8]) begin
                    $error("%s: expected %0d, actual %0d", lane[k], e.data[8*k +: 8],
                           data[8*k +: 8]);
                    errors++;
                end
            end
            if (last !== e.last) begin
                $error("frame_end: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;  // red, green, blue, alpha
    logic        i_s_tuser;        // op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [DATA_W-1:0] o_m_tdata;  // red, green, blue, alpha
    logic        o_m_tlast;        // frame_end

    alpha_keyer  keyer;
    bit          calm, mid_frame, pressure_armed, held;
    int unsigned sent;
    int unsigned quiet;

    color_key_alpha_cross_window_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) keyer.push_item(i_s_tuser, i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready) keyer.check_pixel(o_m_tdata, o_m_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // receiver: random stalls, one long hold-off mid-frame
    initial begin
        i_m_tready = 1'b0;
        held       = 0;
        forever begin
            @(negedge i_clk);
            if (pressure_armed && mid_frame && !held) begin
                held = 1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        keyer.write_reg(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (keyer.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [11:0] w, input logic [12:0] h);
        wait_idle();
        reg_write(REG_RED, 32'(r));
        reg_write(REG_GREEN, 32'(g));
        reg_write(REG_BLUE, 32'(b));
        reg_write(REG_WIDTH, 32'(w));
        reg_write(REG_HEIGHT, 32'(h));
    endtask

    task automatic send_item(input logic op, input logic [31:0] px);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // bias_pct: share of pixels that clear all three thresholds
    function automatic logic [31:0] rand_pixel(int bias_pct);
        logic [31:0] px;
        px = $urandom();
        if ($urandom_range(99) < bias_pct) begin
            px[7:0]   = 8'($urandom_range(255, keyer.thr_red));
            px[15:8]  = 8'($urandom_range(255, keyer.thr_green));
            px[23:16] = 8'($urandom_range(255, keyer.thr_blue));
        end
        return px;
    endfunction

    function automatic logic [7:0] rand_thr();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom());
            default: return 8'($urandom_range(230, 64));
        endcase
    endfunction

    task automatic run_frame(input int bias_pct, input int noise_pct);
        int unsigned w, h;
        w = keyer.eff_width();
        h = keyer.eff_height();
        mid_frame = 1;
        for (int unsigned n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < noise_pct) send_item(OP_FLUSH, $urandom());
            send_item(OP_PIXEL, rand_pixel(bias_pct));
            sent++;
            if (sent >= CALM_AT) calm = 1;
        end
        for (int unsigned n = 0; n < w; n++) begin
            if ($urandom_range(99) < noise_pct) send_item(OP_PIXEL, $urandom());
            send_item(OP_FLUSH, $urandom());
            sent++;
            if (sent >= CALM_AT) calm = 1;
        end
        if ($urandom_range(99) < noise_pct) send_item(OP_FLUSH, $urandom());
        mid_frame = 0;
    endtask

    initial begin
        logic [11:0] w_reg;
        logic [12:0] h_reg;
        keyer          = new();
        calm           = 0;
        mid_frame      = 0;
        pressure_armed = 0;
        sent           = 0;
        quiet          = 0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_s_tvalid     = 1'b0;
        i_s_tuser      = OP_PIXEL;
        i_s_tdata      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // flush tick outside a drain is dropped
        send_item(OP_FLUSH, 32'hFFFFFFFF);

        // 3x3, everything but the corner clears: centre keyed
        configure(8'd200, 8'd100, 8'd50, 12'd3, 13'd3);
        for (int k = 0; k < 9; k++)
            send_item(OP_PIXEL, (k == 0) ? 32'h00000000 : {8'(k * 29), 24'hFFFFFF});
        send_item(OP_FLUSH, 32'h0);
        send_item(OP_PIXEL, 32'hFFFFFFFF);  // pixel during drain is dropped
        send_item(OP_FLUSH, 32'h0);
        send_item(OP_FLUSH, 32'h0);

        // thresholds at maximum, lower neighbour just misses red: centre kept
        configure(8'hFF, 8'hFF, 8'hFF, 12'd3, 13'd3);
        for (int k = 0; k < 9; k++)
            send_item(OP_PIXEL, {8'(8'hFF - k), (k == 7) ? 24'hFFFFFE : 24'hFFFFFF});
        repeat (3) send_item(OP_FLUSH, 32'h0);

        // single pixel frame, drained by one tick
        configure(8'h00, 8'h00, 8'h00, 12'd1, 13'd1);
        send_item(OP_PIXEL, 32'hFFFFFFFF);
        send_item(OP_FLUSH, 32'h0);

        // zero width and zero height clamp to one
        configure(rand_thr(), rand_thr(), rand_thr(), 12'd0, 13'd4);
        run_frame(80, 0);
        configure(rand_thr(), rand_thr(), rand_thr(), 12'd6, 13'd0);
        run_frame(80, 0);
        configure(8'd100, 8'd100, 8'd100, 12'd3, 13'd3);
        run_frame(90, 2);

        sent           = 0;
        calm           = 0;
        pressure_armed = 1;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       w_reg = 12'd0;
                1:       w_reg = 12'd1;
                2:       w_reg = 12'd2;
                default: w_reg = 12'($urandom_range(12, 3));
            endcase
            case ($urandom_range(0, 19))
                0:       h_reg = 13'd0;
                1:       h_reg = 13'd1;
                2:       h_reg = 13'd2;
                default: h_reg = 13'($urandom_range(8, 3));
            endcase
            configure(rand_thr(), rand_thr(), rand_thr(), w_reg, h_reg);
            run_frame($urandom_range(95, 50), $urandom_range(0, 8));
        end

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (keyer.errors == 0 && keyer.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
